>>> rtl/core/quaternion_rotate_compose_assert.svh
// Assertion macros for the quaternion rotate/compose block.
// Needs clk and rst_n in the including module; empty under synthesis.
`ifndef QUATERNION_ROTATE_COMPOSE_ASSERT_SVH
`define QUATERNION_ROTATE_COMPOSE_ASSERT_SVH
`ifndef SYNTHESIS
`define QRC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qrc assertion failed");
`define QRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qrc assertion failed");
`else
`define QRC_ASSERT(label, prop)
`define QRC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/core/qrc_pkg.sv
// Shared types and constants for the quaternion rotate/compose block.
// No dependencies.
package qrc_pkg;

  localparam int FIELD_W   = 16;
  localparam int CFG_IDX_W = 8;
  localparam int LANES     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_W = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROT_I = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROT_J = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ROT_K = CFG_IDX_W'(3);

  localparam logic FUNC_ROTATE  = 1'b0;
  localparam logic FUNC_COMPOSE = 1'b1;

  typedef struct packed {
    logic valid;
    logic func;
  } stg_ctl_t;

endpackage

>>> rtl/core/qrc_if.sv
// Channel interfaces of the quaternion rotate/compose block: input, result, config.
// Depends on qrc_pkg.
interface qrc_in_if import qrc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [FIELD_W-1:0] w_in;
  logic [FIELD_W-1:0] x_in;
  logic [FIELD_W-1:0] y_in;
  logic [FIELD_W-1:0] z_in;

  modport source (output valid, func, w_in, x_in, y_in, z_in, input ready);
  modport sink   (input valid, func, w_in, x_in, y_in, z_in, output ready);
endinterface

interface qrc_out_if import qrc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] w_out;
  logic [FIELD_W-1:0] x_out;
  logic [FIELD_W-1:0] y_out;
  logic [FIELD_W-1:0] z_out;
  logic               saturated;

  modport source (output valid, w_out, x_out, y_out, z_out, saturated, input ready);
  modport sink   (input valid, w_out, x_out, y_out, z_out, saturated, output ready);
endinterface

interface qrc_cfg_if import qrc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIELD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/qrc_prod.sv
// Stage 1: all sixteen products of input components and quaternion components.
// Depends on qrc_pkg.
module qrc_prod import qrc_pkg::*; #(
  parameter int QW = 16,
  parameter int PW = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  stg_ctl_t                            ctl_in,
  output logic                                ready_up,
  input  logic [LANES-1:0][FIELD_W-1:0]       din,
  input  logic [LANES-1:0][QW-1:0]            rot_q,
  output stg_ctl_t                            ctl_out,
  input  logic                                ready_dn,
  output logic [LANES-1:0][LANES-1:0][PW-1:0] prod_out,
  output logic [LANES-2:0][FIELD_W-1:0]       vec_out
);

  logic                                vld_r;
  logic                                func_r;
  logic [LANES-1:0][LANES-1:0][PW-1:0] prod_r;
  logic [LANES-1:0][LANES-1:0][PW-1:0] prod_nxt;
  logic [LANES-2:0][FIELD_W-1:0]       vec_r;

  assign ready_up = !vld_r || ready_dn;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      for (int j = 0; j < LANES; j++) begin
        prod_nxt[i][j] = PW'($signed(din[i])) * PW'($signed(rot_q[j]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_up) begin
      vld_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && ctl_in.valid) begin
      func_r <= ctl_in.func;
      prod_r <= prod_nxt;
      vec_r  <= din[LANES-1:1];
    end
  end

  assign ctl_out  = '{valid: vld_r, func: func_r};
  assign prod_out = prod_r;
  assign vec_out  = vec_r;

endmodule

>>> rtl/core/qrc_sum.sv
// Stage 2: dot and cross product sums, or the Hamilton product sums.
// Depends on qrc_pkg.
module qrc_sum import qrc_pkg::*; #(
  parameter int PW = 32,
  parameter int SW = 35
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  stg_ctl_t                            ctl_in,
  output logic                                ready_up,
  input  logic [LANES-1:0][LANES-1:0][PW-1:0] prod_in,
  input  logic [LANES-2:0][FIELD_W-1:0]       vec_in,
  output stg_ctl_t                            ctl_out,
  input  logic                                ready_dn,
  output logic [LANES-1:0][SW-1:0]            sum_out,
  output logic [LANES-2:0][FIELD_W-1:0]       vec_out
);

  logic                          vld_r;
  logic                          func_r;
  logic [LANES-1:0][SW-1:0]      sum_r;
  logic [LANES-1:0][SW-1:0]      sum_nxt;
  logic [LANES-2:0][FIELD_W-1:0] vec_r;
  logic signed [SW-1:0]          p_s [LANES][LANES];
  logic signed [SW-1:0]          dot_s;
  logic signed [SW-1:0]          ix_s;
  logic signed [SW-1:0]          iy_s;
  logic signed [SW-1:0]          iz_s;

  assign ready_up = !vld_r || ready_dn;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      for (int j = 0; j < LANES; j++) begin
        p_s[i][j] = SW'($signed(prod_in[i][j]));
      end
    end
    dot_s = p_s[1][1] + p_s[2][2] + p_s[3][3];
    ix_s  = p_s[1][0] - p_s[3][2] + p_s[2][3];
    iy_s  = p_s[2][0] - p_s[1][3] + p_s[3][1];
    iz_s  = p_s[3][0] - p_s[2][1] + p_s[1][2];
    if (ctl_in.func == FUNC_COMPOSE) begin
      sum_nxt[0] = p_s[0][0] - dot_s;
      sum_nxt[1] = ix_s + p_s[0][1];
      sum_nxt[2] = iy_s + p_s[0][2];
      sum_nxt[3] = iz_s + p_s[0][3];
    end else begin
      sum_nxt[0] = dot_s;
      sum_nxt[1] = ix_s;
      sum_nxt[2] = iy_s;
      sum_nxt[3] = iz_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_up) begin
      vld_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && ctl_in.valid) begin
      func_r <= ctl_in.func;
      sum_r  <= sum_nxt;
      vec_r  <= vec_in;
    end
  end

  assign ctl_out = '{valid: vld_r, func: func_r};
  assign sum_out = sum_r;
  assign vec_out = vec_r;

endmodule

>>> rtl/core/qrc_scale.sv
// Stages 3 and 4: scale sums by the quaternion (rotate only), then add, double (rotate only) and round.
// Depends on qrc_pkg.
module qrc_scale import qrc_pkg::*; #(
  parameter int FRAC_BITS = 14,
  parameter int QW        = 16,
  parameter int SW        = 35,
  parameter int MW        = 51,
  parameter int TW        = 54
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  stg_ctl_t                      ctl_in,
  output logic                          ready_up,
  input  logic [LANES-1:0][SW-1:0]      sum_in,
  input  logic [LANES-2:0][FIELD_W-1:0] vec_in,
  input  logic [LANES-1:0][QW-1:0]      rot_q,
  output stg_ctl_t                      ctl_out,
  input  logic                          ready_dn,
  output logic [LANES-1:0][TW-1:0]      rnd_out,
  output logic [LANES-2:0][FIELD_W-1:0] vec_out
);

  localparam logic signed [TW-1:0] HALF_COMP = TW'(1) << (FRAC_BITS - 1);
  localparam logic signed [TW-1:0] HALF_ROT  = TW'(1) << (2 * FRAC_BITS - 1);

  logic                          vld3_r;
  logic                          func3_r;
  logic [LANES-1:0][MW-1:0]      pa_r;
  logic [LANES-1:0][MW-1:0]      pa_nxt;
  logic [LANES-1:0][MW-1:0]      pb_r;
  logic [LANES-1:0][MW-1:0]      pb_nxt;
  logic [LANES-2:0][FIELD_W-1:0] vec3_r;
  logic                          ready4;

  logic                          vld4_r;
  logic                          func4_r;
  logic [LANES-1:0][TW-1:0]      rnd_r;
  logic [LANES-1:0][TW-1:0]      rnd_nxt;
  logic [LANES-2:0][FIELD_W-1:0] vec4_r;
  logic signed [TW-1:0]          tot_s      [LANES];
  logic signed [TW-1:0]          pre_rot_s  [LANES];
  logic signed [TW-1:0]          pre_comp_s [LANES];

  assign ready_up = !vld3_r || ready4;
  assign ready4   = !vld4_r || ready_dn;

  always_comb begin
    if (ctl_in.func == FUNC_COMPOSE) begin
      pa_nxt[0] = MW'($signed(sum_in[0]));
    end else begin
      pa_nxt[0] = '0;
    end
    pb_nxt[0] = '0;
    for (int k = 1; k < LANES; k++) begin
      if (ctl_in.func == FUNC_COMPOSE) begin
        pa_nxt[k] = MW'($signed(sum_in[k]));
        pb_nxt[k] = '0;
      end else begin
        pa_nxt[k] = MW'($signed(rot_q[0])) * MW'($signed(sum_in[k]));
        pb_nxt[k] = MW'($signed(sum_in[0])) * MW'($signed(rot_q[k]));
      end
    end
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      tot_s[k]      = TW'($signed(pa_r[k])) + TW'($signed(pb_r[k]));
      pre_rot_s[k]  = (tot_s[k] <<< 1) + HALF_ROT;
      pre_comp_s[k] = tot_s[k] + HALF_COMP;
      if (func3_r == FUNC_COMPOSE) begin
        rnd_nxt[k] = pre_comp_s[k] >>> FRAC_BITS;
      end else begin
        rnd_nxt[k] = pre_rot_s[k] >>> (2 * FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      if (ready_up) begin
        vld3_r <= ctl_in.valid;
      end
      if (ready4) begin
        vld4_r <= vld3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && ctl_in.valid) begin
      func3_r <= ctl_in.func;
      pa_r    <= pa_nxt;
      pb_r    <= pb_nxt;
      vec3_r  <= vec_in;
    end
    if (ready4 && vld3_r) begin
      func4_r <= func3_r;
      rnd_r   <= rnd_nxt;
      vec4_r  <= vec3_r;
    end
  end

  assign ctl_out = '{valid: vld4_r, func: func4_r};
  assign rnd_out = rnd_r;
  assign vec_out = vec4_r;

endmodule

>>> rtl/core/qrc_clip.sv
// Stage 5: subtract the input vector and zero w for rotate, saturate, hold the result beat.
// Depends on qrc_pkg.
module qrc_clip import qrc_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int TW         = 54
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  stg_ctl_t                      ctl_in,
  output logic                          ready_up,
  input  logic [LANES-1:0][TW-1:0]      rnd_in,
  input  logic [LANES-2:0][FIELD_W-1:0] vec_in,
  output stg_ctl_t                      ctl_out,
  input  logic                          ready_dn,
  output logic [LANES-1:0][FIELD_W-1:0] res_out,
  output logic                          sat_out
);

  localparam logic signed [TW-1:0] CLIP_HI = (TW'(1) << (DATA_WIDTH - 1)) - TW'(1);
  localparam logic signed [TW-1:0] CLIP_LO = ~CLIP_HI;

  logic                          vld_r;
  logic                          func_r;
  logic [LANES-1:0][FIELD_W-1:0] res_r;
  logic [LANES-1:0][FIELD_W-1:0] res_nxt;
  logic                          sat_r;
  logic                          sat_nxt;
  logic [LANES-1:0]              lane_sat;
  logic signed [TW-1:0]          val_s [LANES];
  logic signed [TW-1:0]          cl_s  [LANES];

  assign ready_up = !vld_r || ready_dn;

  always_comb begin
    val_s[0] = $signed(rnd_in[0]);
    for (int k = 1; k < LANES; k++) begin
      if (ctl_in.func == FUNC_COMPOSE) begin
        val_s[k] = $signed(rnd_in[k]);
      end else begin
        val_s[k] = $signed(rnd_in[k]) - TW'($signed(vec_in[k-1]));
      end
    end
    for (int k = 0; k < LANES; k++) begin
      lane_sat[k] = 1'b0;
      cl_s[k]     = val_s[k];
      if (val_s[k] > CLIP_HI) begin
        cl_s[k]     = CLIP_HI;
        lane_sat[k] = 1'b1;
      end else if (val_s[k] < CLIP_LO) begin
        cl_s[k]     = CLIP_LO;
        lane_sat[k] = 1'b1;
      end
      res_nxt[k] = cl_s[k][FIELD_W-1:0];
    end
    if (ctl_in.func == FUNC_ROTATE) begin
      res_nxt[0]  = '0;
      lane_sat[0] = 1'b0;
    end
    sat_nxt = |lane_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_up) begin
      vld_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && ctl_in.valid) begin
      func_r <= ctl_in.func;
      res_r  <= res_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign ctl_out = '{valid: vld_r, func: func_r};
  assign res_out = res_r;
  assign sat_out = sat_r;

endmodule

>>> rtl/core/quaternion_rotate_compose.sv
// Top level of the quaternion rotate/compose block: config registers and pipeline.
// Depends on qrc_pkg, qrc_if, qrc_prod, qrc_sum, qrc_scale, qrc_clip.
//
// Usage:
//   cfg_ch writes the rotation quaternion: index 0 rot_w, 1 rot_i, 2 rot_j,
//   3 rot_k (Q1.14); other indexes are taken and dropped. cfg_ch.ready is
//   always high. Write only while no beat is in flight.
//   in_ch carries one beat per item: func 0 rotates (x_in, y_in, z_in) by
//   the quaternion, func 1 forms the Hamilton product of (w_in..z_in) and it.
//   out_ch returns one beat per input beat, in order, saturated to
//   DATA_WIDTH bits, with saturated set if any component was clipped.
//   Throughput: one beat per cycle while out_ch.ready is high, through five register stages
//   (products, sums, scale products, round, saturate).
//   Reset: quaternion returns to identity and the pipeline empties.
//   Stall: when out_ch.ready is low the stages hold and fill from the back;
//   in_ch.ready drops only once every stage holds a beat.
module quaternion_rotate_compose import qrc_pkg::*; #(
  parameter int FRAC_BITS  = 14,
  parameter int DATA_WIDTH = 16
) (
  input logic    clk,
  input logic    rst_n,
  qrc_in_if.sink   in_ch,
  qrc_out_if.source out_ch,
  qrc_cfg_if.sink  cfg_ch
);

`include "quaternion_rotate_compose_assert.svh"

  localparam int QW = (FRAC_BITS + 2 > FIELD_W) ? FRAC_BITS + 2 : FIELD_W;
  localparam int PW = FIELD_W + QW;
  localparam int SW = PW + 3;
  localparam int MW = QW + SW;
  localparam int TW = (MW + 3 > 2 * FRAC_BITS + 2) ? MW + 3 : 2 * FRAC_BITS + 2;

  localparam logic [QW-1:0] ROT_W_RST = QW'(1) << FRAC_BITS;

  logic [QW-1:0] rot_w_r;
  logic [QW-1:0] rot_i_r;
  logic [QW-1:0] rot_j_r;
  logic [QW-1:0] rot_k_r;

  logic [LANES-1:0][QW-1:0]            rot_q;
  logic [LANES-1:0][FIELD_W-1:0]       din;
  stg_ctl_t                            in_ctl;
  stg_ctl_t                            s1_ctl;
  stg_ctl_t                            s2_ctl;
  stg_ctl_t                            s4_ctl;
  stg_ctl_t                            s5_ctl;
  logic                                rdy1;
  logic                                rdy2;
  logic                                rdy3;
  logic                                rdy5;
  logic [LANES-1:0][LANES-1:0][PW-1:0] prod;
  logic [LANES-1:0][SW-1:0]            sums;
  logic [LANES-1:0][TW-1:0]            rnd;
  logic [LANES-2:0][FIELD_W-1:0]       vec1;
  logic [LANES-2:0][FIELD_W-1:0]       vec2;
  logic [LANES-2:0][FIELD_W-1:0]       vec4;
  logic [LANES-1:0][FIELD_W-1:0]       res;
  logic                                sat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_w_r <= ROT_W_RST;
      rot_i_r <= '0;
      rot_j_r <= '0;
      rot_k_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ROT_W: rot_w_r <= QW'($signed(cfg_ch.data));
        REG_ROT_I: rot_i_r <= QW'($signed(cfg_ch.data));
        REG_ROT_J: rot_j_r <= QW'($signed(cfg_ch.data));
        REG_ROT_K: rot_k_r <= QW'($signed(cfg_ch.data));
        default: ;
      endcase
    end
  end

  assign rot_q        = {rot_k_r, rot_j_r, rot_i_r, rot_w_r};
  assign din          = {in_ch.z_in, in_ch.y_in, in_ch.x_in, in_ch.w_in};
  assign in_ctl       = '{valid: in_ch.valid, func: in_ch.func};
  assign in_ch.ready  = rdy1;

  qrc_prod #(.QW(QW), .PW(PW)) u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (in_ctl),
    .ready_up (rdy1),
    .din      (din),
    .rot_q    (rot_q),
    .ctl_out  (s1_ctl),
    .ready_dn (rdy2),
    .prod_out (prod),
    .vec_out  (vec1)
  );

  qrc_sum #(.PW(PW), .SW(SW)) u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (s1_ctl),
    .ready_up (rdy2),
    .prod_in  (prod),
    .vec_in   (vec1),
    .ctl_out  (s2_ctl),
    .ready_dn (rdy3),
    .sum_out  (sums),
    .vec_out  (vec2)
  );

  qrc_scale #(.FRAC_BITS(FRAC_BITS), .QW(QW), .SW(SW), .MW(MW), .TW(TW)) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (s2_ctl),
    .ready_up (rdy3),
    .sum_in   (sums),
    .vec_in   (vec2),
    .rot_q    (rot_q),
    .ctl_out  (s4_ctl),
    .ready_dn (rdy5),
    .rnd_out  (rnd),
    .vec_out  (vec4)
  );

  qrc_clip #(.DATA_WIDTH(DATA_WIDTH), .TW(TW)) u_clip (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (s4_ctl),
    .ready_up (rdy5),
    .rnd_in   (rnd),
    .vec_in   (vec4),
    .ctl_out  (s5_ctl),
    .ready_dn (out_ch.ready),
    .res_out  (res),
    .sat_out  (sat)
  );

  assign out_ch.valid     = s5_ctl.valid;
  assign out_ch.w_out     = res[0];
  assign out_ch.x_out     = res[1];
  assign out_ch.y_out     = res[2];
  assign out_ch.z_out     = res[3];
  assign out_ch.saturated = sat;

  `QRC_ASSERT_NEXT(a_in_enters_s1, in_ch.valid && in_ch.ready, s1_ctl.valid)
  `QRC_ASSERT_NEXT(a_stall_holds_s4, s5_ctl.valid && !out_ch.ready && s4_ctl.valid, s4_ctl.valid)
  `QRC_ASSERT(a_rotate_w_zero, (s5_ctl.valid && s5_ctl.func == FUNC_ROTATE) |-> (res[0] == '0))

endmodule

>>> tb/sv/quaternion_rotate_compose_tb.sv
// Self-checking testbench for quaternion_rotate_compose: rotate and compose beats
// checked against an in-bench fixed-point predictor. Needs qrc_pkg and qrc_if.
`timescale 1ns / 100ps

module quaternion_rotate_compose_tb;
  import qrc_pkg::*;

  localparam int FRAC_BITS   = 14;
  localparam int DATA_WIDTH  = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    logic               func;
    logic [FIELD_W-1:0] w;
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] z;
  } quat_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] w;
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] z;
    logic               sat;
  } quat_result_t;

  logic clk;
  logic rst_n;

  qrc_in_if  in_if();
  qrc_out_if out_if();
  qrc_cfg_if cfg_if();

  quaternion_rotate_compose #(
    .FRAC_BITS (FRAC_BITS),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  logic signed [FIELD_W-1:0] rot_q [LANES];
  quat_item_t   pending_items [$];
  quat_result_t due_results [$];
  quat_item_t   drv_item;
  int           beats_in_flight;
  int           errors;
  bit           no_idle;
  int unsigned  hold_req;
  int unsigned  hold_seen;
  int unsigned  hold_left;
  int unsigned  in_gap;
  int unsigned  out_gap;
  int unsigned  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [FIELD_W-1:0] rand_word(int unsigned mode);
    case (mode)
      0: return FIELD_W'($urandom);
      1: return FIELD_W'($urandom_range(0, 32768) - 16384);
      2: return FIELD_W'($urandom_range(0, 600) - 300);
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'h8000;
          1: return 16'hFFFF;
          2: return 16'h0000;
          3: return 16'h0001;
          4: return 16'h4000;
          default: return 16'h7FFF;
        endcase
      end
    endcase
  endfunction

  function automatic longint round_half_up(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic [FIELD_W-1:0] clamp(longint v, inout bit clipped);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      v = hi;
      clipped = 1'b1;
    end
    if (v < lo) begin
      v = lo;
      clipped = 1'b1;
    end
    return FIELD_W'(v);
  endfunction

  function automatic quat_result_t transform_item(quat_item_t it);
    quat_result_t res;
    longint q0, q1, q2, q3, a, b, c, d, s, tx, ty, tz, pw, px, py, pz;
    bit clipped;
    q0 = longint'(rot_q[0]);
    q1 = longint'(rot_q[1]);
    q2 = longint'(rot_q[2]);
    q3 = longint'(rot_q[3]);
    a = longint'($signed(it.w));
    b = longint'($signed(it.x));
    c = longint'($signed(it.y));
    d = longint'($signed(it.z));
    clipped = 1'b0;
    if (it.func == FUNC_ROTATE) begin
      s  = q1 * b + q2 * c + q3 * d;
      tx = 2 * (q0 * (b * q0 - (q2 * d - q3 * c)) + s * q1);
      ty = 2 * (q0 * (c * q0 - (q3 * b - q1 * d)) + s * q2);
      tz = 2 * (q0 * (d * q0 - (q1 * c - q2 * b)) + s * q3);
      res.w = '0;
      res.x = clamp(round_half_up(tx, 2 * FRAC_BITS) - b, clipped);
      res.y = clamp(round_half_up(ty, 2 * FRAC_BITS) - c, clipped);
      res.z = clamp(round_half_up(tz, 2 * FRAC_BITS) - d, clipped);
    end else begin
      pw = a * q0 - (b * q1 + c * q2 + d * q3);
      px = b * q0 + a * q1 + (c * q3 - d * q2);
      py = c * q0 + a * q2 + (d * q1 - b * q3);
      pz = d * q0 + a * q3 + (b * q2 - c * q1);
      res.w = clamp(round_half_up(pw, FRAC_BITS), clipped);
      res.x = clamp(round_half_up(px, FRAC_BITS), clipped);
      res.y = clamp(round_half_up(py, FRAC_BITS), clipped);
      res.z = clamp(round_half_up(pz, FRAC_BITS), clipped);
    end
    res.sat = clipped;
    return res;
  endfunction

  task automatic check_field(string name, logic signed [FIELD_W-1:0] want,
                             logic signed [FIELD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic queue_item(logic f, logic [FIELD_W-1:0] w, logic [FIELD_W-1:0] x,
                            logic [FIELD_W-1:0] y, logic [FIELD_W-1:0] z);
    quat_item_t it;
    it.func = f;
    it.w = w;
    it.x = x;
    it.y = y;
    it.z = z;
    pending_items.push_back(it);
    beats_in_flight++;
  endtask

  task automatic settle();
    while (beats_in_flight != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic program_rot(logic [FIELD_W-1:0] qw, logic [FIELD_W-1:0] qi,
                             logic [FIELD_W-1:0] qj, logic [FIELD_W-1:0] qk, bit stray);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [FIELD_W-1:0]   val [5];
    int n;
    idx[0] = REG_ROT_W; val[0] = qw;
    idx[1] = REG_ROT_I; val[1] = qi;
    idx[2] = REG_ROT_J; val[2] = qj;
    idx[3] = REG_ROT_K; val[3] = qk;
    idx[4] = CFG_IDX_W'($urandom_range(LANES, (1 << CFG_IDX_W) - 1));
    val[4] = FIELD_W'($urandom);
    n = stray ? 5 : 4;
    cfg_if.valid <= 1'b1;
    for (int k = 0; k < n; k++) begin
      cfg_if.index <= idx[k];
      cfg_if.data  <= val[k];
      do @(posedge clk); while (!cfg_if.ready);
      if (idx[k] < LANES) rot_q[idx[k][1:0]] = val[k];
    end
    cfg_if.valid <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_if.valid && in_if.ready) due_results.push_back(transform_item(drv_item));
      if (in_if.valid && !in_if.ready) begin
      end else if (in_gap > 0) begin
        in_if.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_items.size() > 0) begin
        drv_item = pending_items.pop_front();
        in_if.func  <= drv_item.func;
        in_if.w_in  <= drv_item.w;
        in_if.x_in  <= drv_item.x;
        in_if.y_in  <= drv_item.y;
        in_if.z_in  <= drv_item.z;
        in_if.valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    quat_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_gap <= 0;
      hold_left <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (due_results.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("w_out", want.w, out_if.w_out);
          check_field("x_out", want.x, out_if.x_out);
          check_field("y_out", want.y, out_if.y_out);
          check_field("z_out", want.z, out_if.z_out);
          check_field("saturated", {15'b0, want.sat}, {15'b0, out_if.saturated});
          beats_in_flight--;
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned mode;
    int unsigned r;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.func = FUNC_ROTATE;
    in_if.w_in = '0;
    in_if.x_in = '0;
    in_if.y_in = '0;
    in_if.z_in = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_ROT_W;
    cfg_if.data = '0;
    errors = 0;
    beats_in_flight = 0;
    no_idle = 1'b0;
    hold_req = 0;
    hold_seen = 0;
    quiet_cycles = 0;
    rot_q[0] = 16'sd16384;
    rot_q[1] = '0;
    rot_q[2] = '0;
    rot_q[3] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // identity after reset; w_in ignored on rotate
    queue_item(FUNC_ROTATE,  16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000);
    queue_item(FUNC_COMPOSE, 16'h4000, 16'h4000, 16'h4000, 16'h4000);
    queue_item(FUNC_COMPOSE, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    queue_item(FUNC_ROTATE,  16'h0000, 16'hFFFF, 16'h0001, 16'h8000);
    settle();

    // unnormalized extremes, with a write to an unused index
    program_rot(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    queue_item(FUNC_ROTATE,  16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    queue_item(FUNC_ROTATE,  16'h1234, 16'h8000, 16'h8000, 16'h8000);
    queue_item(FUNC_COMPOSE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    queue_item(FUNC_COMPOSE, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    queue_item(FUNC_ROTATE,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_item(FUNC_COMPOSE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    settle();

    program_rot(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    queue_item(FUNC_ROTATE,  16'h0000, 16'h0001, 16'hFFFF, 16'h0000);
    queue_item(FUNC_COMPOSE, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    queue_item(FUNC_ROTATE,  16'h0000, 16'h8000, 16'h7FFF, 16'h8000);
    queue_item(FUNC_COMPOSE, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
    settle();

    // half-way rounding cases
    program_rot(16'h2000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    queue_item(FUNC_COMPOSE, 16'h0001, 16'hFFFF, 16'h0003, 16'hFFFD);
    queue_item(FUNC_ROTATE,  16'h7FFF, 16'h0001, 16'hFFFF, 16'h0003);
    queue_item(FUNC_ROTATE,  16'h0000, 16'h8000, 16'h8000, 16'h7FFF);
    settle();

    // quarter turn about z
    program_rot(16'd11585, 16'h0000, 16'h0000, 16'd11585, 1'b0);
    queue_item(FUNC_ROTATE,  16'h0000, 16'd100, 16'h0000, 16'h0000);
    queue_item(FUNC_ROTATE,  16'h0000, 16'h0000, 16'd100, 16'd50);
    queue_item(FUNC_COMPOSE, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
    queue_item(FUNC_COMPOSE, 16'd11585, 16'h0000, 16'h0000, -16'sd11585);

    for (int ph = 0; ph < 10; ph++) begin
      settle();
      mode = ph % 4;
      program_rot(rand_word(mode), rand_word(mode), rand_word(mode), rand_word(mode),
                  ph[0]);
      if (ph == 4) begin
        no_idle <= 1'b1;
        hold_req <= hold_req + 1;
      end else begin
        no_idle <= (ph % 3 == 1);
      end
      for (int n = 0; n < 68; n++) begin
        r = $urandom_range(0, 9);
        mode = (r < 7) ? 0 : (r < 9) ? 2 : 3;
        queue_item($urandom_range(0, 1) ? FUNC_COMPOSE : FUNC_ROTATE, rand_word(mode),
                   rand_word(mode), rand_word(mode), rand_word(mode));
      end
    end
    settle();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/qrc_pkg.sv
rtl/core/qrc_if.sv
rtl/core/qrc_prod.sv
rtl/core/qrc_sum.sv
rtl/core/qrc_scale.sv
rtl/core/qrc_clip.sv
rtl/core/quaternion_rotate_compose.sv
tb/sv/quaternion_rotate_compose_tb.sv
